// ===== rtl/bbproj_pkg.sv =====
package bbproj_pkg;

	// Default depth of the quarter-wave sine table
	localparam int SINE_TABLE_ENTRIES_DEF = 1024;

	// Angle units: 1/16 degree
	localparam int QUARTER_TURN = 1440;
	localparam int FULL_TURN    = 5760;

	// pi/2 in Q30, used to build the sine table
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// Reciprocal of a quarter turn, 2^32 / 1440 rounded down
	localparam int          RECIP_SHIFT = 32;
	localparam logic [21:0] RECIP_QUARTER = 22'd2982616;

	// Quotient bits of the pixel divide, saturation level 2^20
	localparam int QUOT_BITS = 21;

	// Image limits after reset
	localparam logic [11:0] LIMIT_X_RESET = 12'd1237;
	localparam logic [11:0] LIMIT_Y_RESET = 12'd370;

	// Taylor term divisors (2n)(2n+1)
	localparam int unsigned TAYLOR_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

	// Configuration register indexes
	typedef enum logic [3:0] {
		CFG_ROW0_A  = 4'd0,
		CFG_ROW0_B  = 4'd1,
		CFG_ROW1_A  = 4'd2,
		CFG_ROW1_B  = 4'd3,
		CFG_ROW2_A  = 4'd4,
		CFG_ROW2_B  = 4'd5,
		CFG_LIMIT_X = 4'd6,
		CFG_LIMIT_Y = 4'd7
	} cfg_idx_t;

	// Box geometry carried through the front stages
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic signed [15:0] cz;
		logic [13:0]        len;
		logic [13:0]        wid;
		logic [13:0]        hgt;
	} box_t;

	// Per-corner control carried alongside the divider
	typedef struct packed {
		logic first;
		logic last;
		logic behind;
		logic neg_x;
		logic neg_y;
		logic zero_x;
		logic zero_y;
	} crn_t;

	// Sine entry in unsigned Q16 from an angle x in Q30 (elaboration only)
	function automatic logic [16:0] sine_q16(input logic [63:0] x);
		logic [63:0] t;
		longint      sum;
		t   = x;
		sum = longint'(x);
		for (int n = 0; n < 7; n++) begin
			t = (t * x) >> 30;
			t = (t * x) >> 30;
			t = t / 64'(TAYLOR_DIV[n]);
			if ((n % 2) == 0)
				sum = sum - longint'(t);
			else
				sum = sum + longint'(t);
		end
		sum = sum + 64'sd8192;
		if (sum < 0)
			sum = 0;
		sum = sum >>> 14;
		if (sum > 65536)
			sum = 65536;
		return 17'(sum);
	endfunction

endpackage

// ===== rtl/box_to_image_bbox_projector_core.sv =====
// Oriented 3D box to 2D image box projector. A box is taken on the slave
// stream and its eight corners are sent, one per clock while not stalled,
// through a shared pipelined projector (3x4 matrix) and a pair of pipelined
// restoring dividers; the enclosing image box comes out on the master stream
// with behind_camera in tuser. The corner sequencer takes the next box on the
// last corner of the current one. From transfer in to result a box passes
// 7 front stages, the corner sequencer, 3 projection stages, 22 divider
// stages and 2 finishing stages.
// The sine table is a constant ROM of SINE_TABLE_ENTRIES+1 entries built at
// elaboration. Configuration must be written only while the block is idle.
module box_to_image_bbox_projector_core
	import bbproj_pkg::*;
#(
	parameter int SINE_TABLE_ENTRIES = SINE_TABLE_ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// fields from bit 0: centre_x[16], centre_y[16], centre_z[16],
	// box_length[14], box_width[14], box_height[14], heading[14]
	input  logic [103:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// fields from bit 0: left_edge[16], top_edge[16], right_edge[17],
	// bottom_edge[17], zero pad[6]
	output logic [71:0]  m_tdata,
	// fields from bit 0: behind_camera[1]
	output logic         m_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         cfg_we,
	input  logic [3:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	localparam int IDX_W  = $clog2(SINE_TABLE_ENTRIES + 1);
	localparam int NUM_W  = $clog2((QUARTER_TURN - 1) * SINE_TABLE_ENTRIES
		+ QUARTER_TURN / 2 + 1);
	localparam int PROD_W = NUM_W + 22;
	localparam int Q0_W   = PROD_W - RECIP_SHIFT;
	localparam int CRD_W  = 21;
	localparam int MUL_W  = 53;
	localparam int P_W    = 56;
	localparam int N_W    = 60;
	localparam int D_W    = 55;
	localparam int CMP_W  = D_W + QUOT_BITS;
	localparam int PIX_W  = 22;
	localparam logic signed [PIX_W-1:0] PIX_SAT = PIX_W'(1 << (QUOT_BITS - 1));

	// ------------------------------------------------------------------
	// Configuration registers
	logic [63:0] proj_q [6];
	logic [11:0] lim_x_q;
	logic [11:0] lim_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++)
				proj_q[i] <= '0;
			lim_x_q <= LIMIT_X_RESET;
			lim_y_q <= LIMIT_Y_RESET;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ROW0_A:  proj_q[0] <= cfg_data;
				CFG_ROW0_B:  proj_q[1] <= cfg_data;
				CFG_ROW1_A:  proj_q[2] <= cfg_data;
				CFG_ROW1_B:  proj_q[3] <= cfg_data;
				CFG_ROW2_A:  proj_q[4] <= cfg_data;
				CFG_ROW2_B:  proj_q[5] <= cfg_data;
				CFG_LIMIT_X: lim_x_q <= cfg_data[11:0];
				CFG_LIMIT_Y: lim_y_q <= cfg_data[11:0];
				default: ;
			endcase
		end
	end

	// Split registers into coefficients
	logic signed [31:0] coef [3][4];
	for (genvar r = 0; r < 3; r++) begin : g_coef_r
		for (genvar c = 0; c < 4; c++) begin : g_coef_c
			assign coef[r][c] = proj_q[r * 2 + c / 2][(c % 2) * 32 +: 32];
		end
	end

	// ------------------------------------------------------------------
	// Quarter-wave sine ROM
	logic [16:0] sine_rom [SINE_TABLE_ENTRIES + 1];
	for (genvar k = 0; k <= SINE_TABLE_ENTRIES; k++) begin : g_rom
		localparam logic [63:0] XK = HALF_PI_Q30 * 64'(k) / 64'(SINE_TABLE_ENTRIES);
		assign sine_rom[k] = sine_q16(XK);
	end

	// ------------------------------------------------------------------
	// Stall control
	logic       cen;
	logic       busy_q;
	logic [2:0] cnt_q;
	logic       load_ok;
	logic       seq_load;
	logic       fin_v_s;
	crn_t       fin_f_s;
	logic       out_v_q;

	// Hold the corner pipeline only when a finished box cannot leave
	assign cen      = !(fin_v_s && fin_f_s.last && out_v_q && !m_tready);
	assign load_ok  = !busy_q || (cnt_q == 3'd7);

	// ------------------------------------------------------------------
	// Box front pipeline, stages 1 to 7
	logic bv_s1, bv_s2, bv_s3, bv_s4, bv_s5, bv_s6, bv_s7;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7;

	assign rdy7     = !bv_s7 || (cen && load_ok);
	assign rdy6     = !bv_s6 || rdy7;
	assign rdy5     = !bv_s5 || rdy6;
	assign rdy4     = !bv_s4 || rdy5;
	assign rdy3     = !bv_s3 || rdy4;
	assign rdy2     = !bv_s2 || rdy3;
	assign rdy1     = !bv_s1 || rdy2;
	assign s_tready = rdy1;
	assign seq_load = bv_s7 && cen && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_s1 <= 1'b0;
			bv_s2 <= 1'b0;
			bv_s3 <= 1'b0;
			bv_s4 <= 1'b0;
			bv_s5 <= 1'b0;
			bv_s6 <= 1'b0;
			bv_s7 <= 1'b0;
		end else begin
			if (rdy1) bv_s1 <= s_tvalid;
			if (rdy2) bv_s2 <= bv_s1;
			if (rdy3) bv_s3 <= bv_s2;
			if (rdy4) bv_s4 <= bv_s3;
			if (rdy5) bv_s5 <= bv_s4;
			if (rdy6) bv_s6 <= bv_s5;
			if (rdy7) bv_s7 <= bv_s6;
		end
	end

	// Stage 1: unpack and reduce heading to one turn
	box_t               box_s1;
	logic [12:0]        ang_s1;
	logic signed [14:0] hs, a1, a2;

	always_comb begin
		hs = {s_tdata[103], s_tdata[103:90]};
		a1 = (hs < 0) ? hs + 15'sd5760 : hs;
		if (a1 < 0)
			a2 = a1 + 15'sd5760;
		else if (a1 >= 15'sd5760)
			a2 = a1 - 15'sd5760;
		else
			a2 = a1;
	end

	always_ff @(posedge clk) begin
		if (rdy1 && s_tvalid) begin
			box_s1.cx  <= s_tdata[15:0];
			box_s1.cy  <= s_tdata[31:16];
			box_s1.cz  <= s_tdata[47:32];
			box_s1.len <= s_tdata[61:48];
			box_s1.wid <= s_tdata[75:62];
			box_s1.hgt <= s_tdata[89:76];
			ang_s1     <= a2[12:0];
		end
	end

	// Stage 2: quadrant and remainder
	box_t        box_s2;
	logic [1:0]  quad_s2;
	logic [10:0] rem_s2;
	logic [1:0]  quad_c;
	logic [10:0] rem_c;

	always_comb begin
		if (ang_s1 >= 13'd4320) begin
			quad_c = 2'd3;
			rem_c  = 11'(ang_s1 - 13'd4320);
		end else if (ang_s1 >= 13'd2880) begin
			quad_c = 2'd2;
			rem_c  = 11'(ang_s1 - 13'd2880);
		end else if (ang_s1 >= 13'd1440) begin
			quad_c = 2'd1;
			rem_c  = 11'(ang_s1 - 13'd1440);
		end else begin
			quad_c = 2'd0;
			rem_c  = ang_s1[10:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && bv_s1) begin
			box_s2  <= box_s1;
			quad_s2 <= quad_c;
			rem_s2  <= rem_c;
		end
	end

	// Stage 3: scale remainder to table index numerator
	box_t             box_s3;
	logic [1:0]       quad_s3;
	logic [NUM_W-1:0] num_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && bv_s2) begin
			box_s3  <= box_s2;
			quad_s3 <= quad_s2;
			num_s3  <= NUM_W'(rem_s2) * NUM_W'(SINE_TABLE_ENTRIES)
				+ NUM_W'(QUARTER_TURN / 2);
		end
	end

	// Stage 4: multiply by reciprocal of a quarter turn
	box_t              box_s4;
	logic [1:0]        quad_s4;
	logic [NUM_W-1:0]  num_s4;
	logic [PROD_W-1:0] prod_s4;

	always_ff @(posedge clk) begin
		if (rdy4 && bv_s3) begin
			box_s4  <= box_s3;
			quad_s4 <= quad_s3;
			num_s4  <= num_s3;
			prod_s4 <= PROD_W'(num_s3) * PROD_W'(RECIP_QUARTER);
		end
	end

	// Stage 5: correct quotient, mirror for odd quadrants
	box_t             box_s5;
	logic [IDX_W-1:0] sidx_s5, cidx_s5;
	logic             sneg_s5, cneg_s5;
	logic [Q0_W-1:0]  q0;
	logic [NUM_W:0]   qm, rm;
	logic [Q0_W:0]    idx_f;
	logic [IDX_W-1:0] idx_c, mir_c;
	logic [1:0]       cquad_c;

	always_comb begin
		q0      = prod_s4[PROD_W-1:RECIP_SHIFT];
		qm      = (NUM_W + 1)'(q0) * (NUM_W + 1)'(QUARTER_TURN);
		rm      = {1'b0, num_s4} - qm;
		idx_f   = (rm >= (NUM_W + 1)'(QUARTER_TURN)) ? {1'b0, q0} + 1'b1 : {1'b0, q0};
		idx_c   = idx_f[IDX_W-1:0];
		mir_c   = IDX_W'(SINE_TABLE_ENTRIES) - idx_c;
		cquad_c = quad_s4 + 2'd1;
	end

	always_ff @(posedge clk) begin
		if (rdy5 && bv_s4) begin
			box_s5  <= box_s4;
			sidx_s5 <= quad_s4[0] ? mir_c : idx_c;
			cidx_s5 <= cquad_c[0] ? mir_c : idx_c;
			sneg_s5 <= quad_s4[1];
			cneg_s5 <= cquad_c[1];
		end
	end

	// Stage 6: table reads
	box_t        box_s6;
	logic [16:0] sm_s6, cm_s6;
	logic        sneg_s6, cneg_s6;

	always_ff @(posedge clk) begin
		if (rdy6 && bv_s5) begin
			box_s6  <= box_s5;
			sm_s6   <= sine_rom[sidx_s5];
			cm_s6   <= sine_rom[cidx_s5];
			sneg_s6 <= sneg_s5;
			cneg_s6 <= cneg_s5;
		end
	end

	// Stage 7: corner offsets
	box_t               box_s7;
	logic signed [31:0] cl_s7, sw_s7, sl_s7, cw_s7;
	logic signed [17:0] sv, cv;
	logic signed [14:0] lenw, widw;
	logic signed [32:0] cl_m, sw_m, sl_m, cw_m;

	always_comb begin
		sv   = sneg_s6 ? -$signed({1'b0, sm_s6}) : $signed({1'b0, sm_s6});
		cv   = cneg_s6 ? -$signed({1'b0, cm_s6}) : $signed({1'b0, cm_s6});
		lenw = $signed({1'b0, box_s6.len});
		widw = $signed({1'b0, box_s6.wid});
		cl_m = lenw * cv;
		sw_m = widw * sv;
		sl_m = lenw * sv;
		cw_m = widw * cv;
	end

	always_ff @(posedge clk) begin
		if (rdy7 && bv_s6) begin
			box_s7 <= box_s6;
			cl_s7  <= cl_m[31:0];
			sw_s7  <= sw_m[31:0];
			sl_s7  <= sl_m[31:0];
			cw_s7  <= cw_m[31:0];
		end
	end

	// ------------------------------------------------------------------
	// Corner sequencer: one corner per cycle while not stalled, loads next box on the last
	box_t               sq_box_q;
	logic signed [31:0] sq_cl_q, sq_sw_q, sq_sl_q, sq_cw_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else if (cen) begin
			if (!busy_q || cnt_q == 3'd7) begin
				busy_q <= seq_load;
				cnt_q  <= 3'd0;
			end else begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_load) begin
			sq_box_q <= box_s7;
			sq_cl_q  <= cl_s7;
			sq_sw_q  <= sw_s7;
			sq_sl_q  <= sl_s7;
			sq_cw_q  <= cw_s7;
		end
	end

	// ------------------------------------------------------------------
	// Corner stage 1: corner coordinates in 2^-12 m
	logic                    cv_s1;
	logic                    cfirst_s1, clast_s1;
	logic signed [CRD_W-1:0] crd_s1 [3];
	logic signed [35:0]      cxw, cyw, clw, sww, slw, cww, sx, sy;
	logic signed [16:0]      ztop;
	logic signed [CRD_W-1:0] zc;

	always_comb begin
		cxw  = {{3{sq_box_q.cx[15]}}, sq_box_q.cx, 17'b0};
		cyw  = {{3{sq_box_q.cy[15]}}, sq_box_q.cy, 17'b0};
		clw  = {{4{sq_cl_q[31]}}, sq_cl_q};
		sww  = {{4{sq_sw_q[31]}}, sq_sw_q};
		slw  = {{4{sq_sl_q[31]}}, sq_sl_q};
		cww  = {{4{sq_cw_q[31]}}, sq_cw_q};
		sx   = cxw + (cnt_q[1] ? -clw : clw) + (cnt_q[0] ? -sww : sww) + 36'sd4096;
		sy   = cyw + (cnt_q[1] ? -slw : slw) - (cnt_q[0] ? -cww : cww) + 36'sd4096;
		ztop = $signed({sq_box_q.cz[15], sq_box_q.cz}) + $signed({3'b0, sq_box_q.hgt});
		zc   = cnt_q[2] ? {sq_box_q.cz[15], sq_box_q.cz, 4'b0} : {ztop, 4'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_s1 <= 1'b0;
		else if (cen)
			cv_s1 <= busy_q;
	end

	always_ff @(posedge clk) begin
		if (cen) begin
			crd_s1[0] <= sx[33:13];
			crd_s1[1] <= sy[33:13];
			crd_s1[2] <= zc;
			cfirst_s1 <= (cnt_q == 3'd0);
			clast_s1  <= (cnt_q == 3'd7);
		end
	end

	// Corner stage 2: matrix products
	logic                    cv_s2;
	logic                    cfirst_s2, clast_s2;
	logic signed [MUL_W-1:0] mul_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_s2 <= 1'b0;
		else if (cen)
			cv_s2 <= cv_s1;
	end

	always_ff @(posedge clk) begin
		if (cen) begin
			cfirst_s2 <= cfirst_s1;
			clast_s2  <= clast_s1;
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					mul_s2[r][c] <= coef[r][c] * crd_s1[c];
		end
	end

	// Corner stage 3: row sums
	logic                  cv_s3;
	logic                  cfirst_s3, clast_s3;
	logic signed [P_W-1:0] row_s3 [3];
	logic signed [P_W-1:0] row_c [3];

	always_comb begin
		for (int r = 0; r < 3; r++)
			row_c[r] = {{3{mul_s2[r][0][MUL_W-1]}}, mul_s2[r][0]}
				+ {{3{mul_s2[r][1][MUL_W-1]}}, mul_s2[r][1]}
				+ {{3{mul_s2[r][2][MUL_W-1]}}, mul_s2[r][2]}
				+ {{12{coef[r][3][31]}}, coef[r][3], 12'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cv_s3 <= 1'b0;
		else if (cen)
			cv_s3 <= cv_s2;
	end

	always_ff @(posedge clk) begin
		if (cen) begin
			cfirst_s3 <= cfirst_s2;
			clast_s3  <= clast_s2;
			for (int r = 0; r < 3; r++)
				row_s3[r] <= row_c[r];
		end
	end

	// Corner stage 4 (divider entry): magnitudes, rounding bias, flags
	logic                  dv_s [QUOT_BITS + 1];
	crn_t                  df_s [QUOT_BITS + 1];
	logic [D_W-1:0]        dd_s [QUOT_BITS + 1];
	logic [N_W-1:0]        dxr_s [QUOT_BITS + 1];
	logic [N_W-1:0]        dyr_s [QUOT_BITS + 1];
	logic [QUOT_BITS-1:0]  dxq_s [QUOT_BITS + 1];
	logic [QUOT_BITS-1:0]  dyq_s [QUOT_BITS + 1];
	logic                  dxs_s [QUOT_BITS + 1];
	logic                  dys_s [QUOT_BITS + 1];
	logic signed [P_W-1:0] magx, magy;
	logic [N_W-1:0]        bias;
	crn_t                  f_c;

	always_comb begin
		magx       = row_s3[0][P_W-1] ? -row_s3[0] : row_s3[0];
		magy       = row_s3[1][P_W-1] ? -row_s3[1] : row_s3[1];
		bias       = {5'b0, row_s3[2][P_W-1:1]};
		f_c.first  = cfirst_s3;
		f_c.last   = clast_s3;
		f_c.behind = (row_s3[2] <= 0);
		f_c.neg_x  = row_s3[0][P_W-1];
		f_c.neg_y  = row_s3[1][P_W-1];
		f_c.zero_x = (row_s3[0] == 0);
		f_c.zero_y = (row_s3[1] == 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_s[0] <= 1'b0;
		else if (cen)
			dv_s[0] <= cv_s3;
	end

	always_ff @(posedge clk) begin
		if (cen) begin
			df_s[0]  <= f_c;
			dd_s[0]  <= row_s3[2][D_W-1:0];
			dxr_s[0] <= {magx, 4'b0} + bias;
			dyr_s[0] <= {magy, 4'b0} + bias;
			dxq_s[0] <= '0;
			dyq_s[0] <= '0;
			dxs_s[0] <= 1'b0;
			dys_s[0] <= 1'b0;
		end
	end

	// Restoring divide steps, one quotient bit per stage from the top
	for (genvar j = 1; j <= QUOT_BITS; j++) begin : g_div
		localparam int K = QUOT_BITS - j;
		logic [CMP_W-1:0] dsh, dsat;
		logic             gx, gy, sx_n, sy_n;

		assign dsh  = CMP_W'(dd_s[j-1]) << K;
		assign dsat = CMP_W'(dd_s[j-1]) << QUOT_BITS;
		assign gx   = CMP_W'(dxr_s[j-1]) >= dsh;
		assign gy   = CMP_W'(dyr_s[j-1]) >= dsh;
		assign sx_n = (j == 1) ? (CMP_W'(dxr_s[j-1]) >= dsat) : dxs_s[j-1];
		assign sy_n = (j == 1) ? (CMP_W'(dyr_s[j-1]) >= dsat) : dys_s[j-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_s[j] <= 1'b0;
			else if (cen)
				dv_s[j] <= dv_s[j-1];
		end

		always_ff @(posedge clk) begin
			if (cen) begin
				df_s[j]  <= df_s[j-1];
				dd_s[j]  <= dd_s[j-1];
				dxs_s[j] <= sx_n;
				dys_s[j] <= sy_n;
				dxr_s[j] <= gx ? dxr_s[j-1] - dsh[N_W-1:0] : dxr_s[j-1];
				dyr_s[j] <= gy ? dyr_s[j-1] - dsh[N_W-1:0] : dyr_s[j-1];
				dxq_s[j] <= dxq_s[j-1] | (QUOT_BITS'(gx) << K);
				dyq_s[j] <= dyq_s[j-1] | (QUOT_BITS'(gy) << K);
			end
		end
	end

	// Finishing stage: saturate, apply sign, handle depth at or below zero
	logic signed [PIX_W-1:0] u_fin_s, v_fin_s;
	logic signed [PIX_W-1:0] u_c, v_c, qxs, qys;
	logic [QUOT_BITS-1:0]    qx, qy;
	crn_t                    fl;

	always_comb begin
		fl  = df_s[QUOT_BITS];
		qx  = dxq_s[QUOT_BITS];
		qy  = dyq_s[QUOT_BITS];
		qxs = (dxs_s[QUOT_BITS] || $signed({1'b0, qx}) > PIX_SAT) ? PIX_SAT
			: $signed({1'b0, qx});
		qys = (dys_s[QUOT_BITS] || $signed({1'b0, qy}) > PIX_SAT) ? PIX_SAT
			: $signed({1'b0, qy});
		if (fl.behind) begin
			u_c = fl.zero_x ? '0 : (fl.neg_x ? -PIX_SAT : PIX_SAT);
			v_c = fl.zero_y ? '0 : (fl.neg_y ? -PIX_SAT : PIX_SAT);
		end else begin
			u_c = fl.neg_x ? -qxs : qxs;
			v_c = fl.neg_y ? -qys : qys;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fin_v_s <= 1'b0;
		else if (cen)
			fin_v_s <= dv_s[QUOT_BITS];
	end

	always_ff @(posedge clk) begin
		if (cen) begin
			fin_f_s <= fl;
			u_fin_s <= u_c;
			v_fin_s <= v_c;
		end
	end

	// ------------------------------------------------------------------
	// Running extremes over the eight corners
	logic signed [PIX_W-1:0] mnx_q, mxx_q, mny_q, mxy_q;
	logic                    bh_q;
	logic signed [PIX_W-1:0] mnx_n, mxx_n, mny_n, mxy_n;
	logic                    bh_n;

	always_comb begin
		if (fin_f_s.first) begin
			mnx_n = u_fin_s;
			mxx_n = u_fin_s;
			mny_n = v_fin_s;
			mxy_n = v_fin_s;
			bh_n  = fin_f_s.behind;
		end else begin
			mnx_n = (u_fin_s < mnx_q) ? u_fin_s : mnx_q;
			mxx_n = (u_fin_s > mxx_q) ? u_fin_s : mxx_q;
			mny_n = (v_fin_s < mny_q) ? v_fin_s : mny_q;
			mxy_n = (v_fin_s > mxy_q) ? v_fin_s : mxy_q;
			bh_n  = bh_q | fin_f_s.behind;
		end
	end

	always_ff @(posedge clk) begin
		if (cen && fin_v_s) begin
			mnx_q <= mnx_n;
			mxx_q <= mxx_n;
			mny_q <= mny_n;
			mxy_q <= mxy_n;
			bh_q  <= bh_n;
		end
	end

	// Clamp to the image and hold the result for transfer
	logic [15:0]             left_q, top_q;
	logic [16:0]             right_q, bottom_q;
	logic                    obh_q;
	logic signed [PIX_W-1:0] limx, limy;
	logic [15:0]             left_c, top_c;
	logic signed [PIX_W-1:0] right_c, bottom_c;

	always_comb begin
		limx     = $signed({6'b0, lim_x_q, 4'b0});
		limy     = $signed({6'b0, lim_y_q, 4'b0});
		left_c   = (mnx_n < 0) ? 16'd0 : ((mnx_n > 22'sd65535) ? 16'hFFFF : mnx_n[15:0]);
		top_c    = (mny_n < 0) ? 16'd0 : ((mny_n > 22'sd65535) ? 16'hFFFF : mny_n[15:0]);
		right_c  = (mxx_n > limx) ? limx : ((mxx_n < -22'sd65536) ? -22'sd65536 : mxx_n);
		bottom_c = (mxy_n > limy) ? limy : ((mxy_n < -22'sd65536) ? -22'sd65536 : mxy_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (cen && fin_v_s && fin_f_s.last)
			out_v_q <= 1'b1;
		else if (m_tready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cen && fin_v_s && fin_f_s.last) begin
			left_q   <= left_c;
			top_q    <= top_c;
			right_q  <= right_c[16:0];
			bottom_q <= bottom_c[16:0];
			obh_q    <= bh_n;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, bottom_q, right_q, top_q, left_q};
	assign m_tuser  = obh_q;

`ifndef NO_ASSERTIONS
	// Idle sequencer sits at the first corner
	assert property (@(posedge clk) disable iff (!arst_n) !busy_q |-> cnt_q == 3'd0)
		else $error("corner counter moved while sequencer idle");

	// A stalled pipeline issues no corner
	assert property (@(posedge clk) disable iff (!arst_n) !cen |=> $stable(cnt_q))
		else $error("corner issued during stall");

	// A finished box waiting on a full output is not lost
	assert property (@(posedge clk) disable iff (!arst_n)
		(fin_v_s && fin_f_s.last && out_v_q && !m_tready) |=> fin_v_s)
		else $error("last corner dropped during output stall");

	// Divider result stays within saturation
	assert property (@(posedge clk) disable iff (!arst_n)
		fin_v_s |-> (u_fin_s <= PIX_SAT && u_fin_s >= -PIX_SAT
			&& v_fin_s <= PIX_SAT && v_fin_s >= -PIX_SAT))
		else $error("pixel quotient out of range");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
	import bbproj_pkg::*;

	localparam int N_SINE = SINE_TABLE_ENTRIES_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 60;

	typedef struct packed {
		logic signed [13:0] heading;
		logic [13:0]        hgt;
		logic [13:0]        wid;
		logic [13:0]        len;
		logic signed [15:0] cz;
		logic signed [15:0] cy;
		logic signed [15:0] cx;
	} box_item_t;

	typedef struct packed {
		logic               behind;
		logic signed [16:0] bottom;
		logic signed [16:0] right;
		logic [15:0]        top;
		logic [15:0]        left;
	} image_box_t;

	logic         clk;
	logic         arst_n;
	logic [103:0] s_tdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [71:0]  m_tdata;
	logic         m_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic         cfg_we;
	logic [3:0]   cfg_index;
	logic [63:0]  cfg_data;

	// predictor copy of the configuration and the sine ROM
	logic [63:0] proj_rows [6];
	logic [11:0] limit_x;
	logic [11:0] limit_y;
	longint      sine_q16 [N_SINE + 1];

	image_box_t expected_boxes [$];
	int         cycle_count;
	bit         failed;
	bit         calm;
	bit         hold_req;
	int         hold_cnt;
	int         stall_cnt;

	box_to_image_bbox_projector_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tdata(s_tdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// quarter-wave table, Taylor series in Q30 rounded to Q16
	function automatic void fill_sine();
		longint unsigned x, t;
		longint          sum;
		for (int k = 0; k <= N_SINE; k++) begin
			x   = HALF_PI_Q30 * longint'(k) / longint'(N_SINE);
			t   = x;
			sum = longint'(x);
			for (int n = 1; n <= 7; n++) begin
				t = (t * x) >> 30;
				t = (t * x) >> 30;
				t = t / longint'((2 * n) * (2 * n + 1));
				sum = (n % 2) ? sum - longint'(t) : sum + longint'(t);
			end
			sum = sum + 8192;
			if (sum < 0)
				sum = 0;
			sum = sum / 16384;
			if (sum > 65536)
				sum = 65536;
			sine_q16[k] = sum;
		end
	endfunction

	function automatic longint sine_at(int a);
		int     q, r, idx;
		longint m;
		q   = a / QUARTER_TURN;
		r   = a % QUARTER_TURN;
		idx = (r * N_SINE + QUARTER_TURN / 2) / QUARTER_TURN;
		if (idx > N_SINE)
			idx = N_SINE;
		m = (q % 2) ? sine_q16[N_SINE - idx] : sine_q16[idx];
		return (q >= 2) ? -m : m;
	endfunction

	// floor of (s + half) / 8192: 2^-25 m to 2^-12 m
	function automatic longint metres_q12(longint s);
		longint v;
		v = s + 4096;
		if (v >= 0)
			return v / 8192;
		return -((-v + 8191) / 8192);
	endfunction

	function automatic longint coef_of(int row, int col);
		logic [63:0] w;
		w = proj_rows[row * 2 + col / 2];
		return (col % 2) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
	endfunction

	function automatic longint pixel_div(longint num, longint den);
		longint unsigned mag, q;
		if (den <= 0)
			return (num > 0) ? 64'sd1048576 : ((num < 0) ? -64'sd1048576 : 64'sd0);
		mag = (num < 0) ? longint'(-num) : num;
		q   = (mag * 16 + longint'(den) / 2) / longint'(den);
		if (q > 1048576)
			q = 1048576;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic image_box_t project_box(box_item_t b);
		image_box_t res;
		int         a;
		longint     s, c, cl, sw, sl, cw, x, y, z, u, v, sa, sb;
		longint     p [3];
		longint     minx, maxx, miny, maxy;
		bit         behind;
		a = int'(b.heading) % FULL_TURN;
		if (a < 0)
			a += FULL_TURN;
		s  = sine_at(a);
		c  = sine_at((a + QUARTER_TURN) % FULL_TURN);
		cl = longint'(b.len) * c;
		sw = longint'(b.wid) * s;
		sl = longint'(b.len) * s;
		cw = longint'(b.wid) * c;
		behind = 1'b0;
		minx = 0; maxx = 0; miny = 0; maxy = 0;
		for (int i = 0; i < 8; i++) begin
			sa = (i & 2) ? -1 : 1;
			sb = (i & 1) ? -1 : 1;
			x  = metres_q12(longint'(b.cx) * 131072 + sa * cl + sb * sw);
			y  = metres_q12(longint'(b.cy) * 131072 + sa * sl - sb * cw);
			z  = (i < 4) ? (longint'(b.cz) + longint'(b.hgt)) * 16 : longint'(b.cz) * 16;
			for (int r = 0; r < 3; r++)
				p[r] = coef_of(r, 0) * x + coef_of(r, 1) * y + coef_of(r, 2) * z
					+ coef_of(r, 3) * 4096;
			if (p[2] <= 0)
				behind = 1'b1;
			u = pixel_div(p[0], p[2]);
			v = pixel_div(p[1], p[2]);
			if (i == 0 || u < minx) minx = u;
			if (i == 0 || u > maxx) maxx = u;
			if (i == 0 || v < miny) miny = v;
			if (i == 0 || v > maxy) maxy = v;
		end
		minx = (minx < 0) ? 0 : ((minx > 65535) ? 65535 : minx);
		miny = (miny < 0) ? 0 : ((miny > 65535) ? 65535 : miny);
		maxx = (maxx < -65536) ? -65536
			: ((maxx > longint'(limit_x) * 16) ? longint'(limit_x) * 16 : maxx);
		maxy = (maxy < -65536) ? -65536
			: ((maxy > longint'(limit_y) * 16) ? longint'(limit_y) * 16 : maxy);
		res.left   = minx[15:0];
		res.top    = miny[15:0];
		res.right  = maxx[16:0];
		res.bottom = maxy[16:0];
		res.behind = behind;
		return res;
	endfunction

	// write one register; the predictor follows, unknown indexes are dropped
	task automatic write_reg(logic [3:0] idx, logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx <= CFG_ROW2_B)
			proj_rows[idx] = value;
		else if (idx == CFG_LIMIT_X)
			limit_x = value[11:0];
		else if (idx == CFG_LIMIT_Y)
			limit_y = value[11:0];
		@(posedge clk);
	endtask

	// drop valid and wait until every box has come back and the pipe is empty
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_boxes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pinhole camera looking down +x: u*d = px*x - f*y + off, v*d = py*x - f*z + off
	task automatic set_camera(int f, int px, int py, int off, int lx, int ly);
		write_reg(CFG_ROW0_A, {32'(-(f <<< 20)), 32'(px <<< 20)});
		write_reg(CFG_ROW0_B, {32'(off), 32'd0});
		write_reg(CFG_ROW1_A, {32'd0, 32'(py <<< 20)});
		write_reg(CFG_ROW1_B, {32'(off), 32'(-(f <<< 20))});
		write_reg(CFG_ROW2_A, {32'd0, 32'(1 <<< 20)});
		write_reg(CFG_ROW2_B, {32'd0, 32'd0});
		write_reg(CFG_LIMIT_X, 64'(lx));
		write_reg(CFG_LIMIT_Y, 64'(ly));
	endtask

	// offer one box, hold it until the transfer, then maybe idle
	task automatic send_box(box_item_t b);
		bit taken;
		s_tdata  <= b;
		s_tvalid <= 1'b1;
		do begin
			@(negedge clk);
			taken = s_tready;
			@(posedge clk);
		end while (!taken);
		expected_boxes.push_back(project_box(b));
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic box_item_t mk_box(int cx, int cy, int cz, int l, int w, int h, int hd);
		box_item_t b;
		b.cx = 16'(cx); b.cy = 16'(cy); b.cz = 16'(cz);
		b.len = 14'(l); b.wid = 14'(w); b.hgt = 14'(h);
		b.heading = 14'(hd);
		return b;
	endfunction

	// mostly plausible boxes in front of the camera, some raw bit patterns
	function automatic box_item_t rand_box();
		box_item_t b;
		if ($urandom_range(0, 4) == 0) begin
			b = 104'({$urandom, $urandom, $urandom, $urandom});
		end else begin
			b = mk_box($urandom_range(256, 20000), int'($urandom_range(0, 10240)) - 5120,
				int'($urandom_range(0, 1024)) - 768, $urandom_range(0, 1536),
				$urandom_range(0, 640), $urandom_range(0, 640),
				int'($urandom_range(0, 11520)) - 5760);
			if ($urandom_range(0, 9) == 0)
				b.heading = 14'($urandom);
		end
		return b;
	endfunction

	// receiver: random stalls, plus long hold-offs on request
	always @(posedge clk) begin
		logic rdy;
		rdy = 1'b1;
		if (hold_req && hold_cnt == 0) begin
			hold_req = 1'b0;
			hold_cnt = 400;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			rdy = 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			rdy = 1'b0;
		end else if (!calm && $urandom_range(0, 4) == 0) begin
			stall_cnt = $urandom_range(0, 8);
			rdy = 1'b0;
		end
		m_tready <= rdy;
	end

	// compare each transfer out with the oldest expected box
	always @(negedge clk) begin
		image_box_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got.left   = m_tdata[15:0];
			got.top    = m_tdata[31:16];
			got.right  = m_tdata[48:32];
			got.bottom = m_tdata[65:49];
			got.behind = m_tuser;
			if (expected_boxes.size() == 0) begin
				$display("%0t: unexpected box %h", $realtime, got);
				failed = 1'b1;
			end else begin
				want = expected_boxes.pop_front();
				if (got.left !== want.left) begin
					$display("%0t: left_edge exp %0d got %0d", $realtime, want.left, got.left);
					failed = 1'b1;
				end
				if (got.top !== want.top) begin
					$display("%0t: top_edge exp %0d got %0d", $realtime, want.top, got.top);
					failed = 1'b1;
				end
				if (got.right !== want.right) begin
					$display("%0t: right_edge exp %0d got %0d", $realtime, want.right,
						got.right);
					failed = 1'b1;
				end
				if (got.bottom !== want.bottom) begin
					$display("%0t: bottom_edge exp %0d got %0d", $realtime, want.bottom,
						got.bottom);
					failed = 1'b1;
				end
				if (got.behind !== want.behind) begin
					$display("%0t: behind_camera exp %0d got %0d", $realtime, want.behind,
						got.behind);
					failed = 1'b1;
				end
			end
		end
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[box_to_image_bbox_projector_core] ERROR");
			$finish;
		end
	end

	// reset matrix: every depth is zero, so every corner is behind
	task automatic test_reset_matrix();
		send_box(mk_box(2560, 0, 0, 1024, 512, 512, 0));
		send_box(mk_box(-32768, 32767, -1, 16383, 16383, 16383, 100));
		drain();
	endtask

	// field extremes and the cardinal headings
	task automatic test_extremes();
		int hds [10] = '{0, 1440, 2880, -1440, -2880, 5760, -5760, -8192, 8191, 720};
		set_camera(700, 600, 180, 12345, 1237, 370);
		foreach (hds[i])
			send_box(mk_box(2560, 256, -256, 1024, 460, 400, hds[i]));
		send_box(mk_box(32767, 32767, 32767, 16383, 16383, 16383, 0));
		send_box(mk_box(32767, -32768, -32768, 0, 0, 0, 0));
		send_box(mk_box(2560, 0, 0, 0, 0, 0, 3333));
		drain();
	endtask

	// boxes straddling or behind the image plane, and a zero image limit
	task automatic test_behind_camera();
		set_camera(1000, 2047, 2047, -7, 0, 4095);
		send_box(mk_box(-2560, 0, 0, 1024, 512, 400, 0));
		send_box(mk_box(256, 0, 0, 2048, 512, 400, 1440));
		send_box(mk_box(0, 0, 0, 0, 0, 0, 0));
		send_box(mk_box(-32768, -32768, 0, 16383, 16383, 0, 0));
		drain();
	endtask

	// hold the receiver off while boxes keep coming so the input stalls
	task automatic test_backpressure();
		set_camera(720, 620, 190, 0, 1237, 370);
		hold_req = 1'b1;
		repeat (60)
			send_box(rand_box());
		drain();
	endtask

	// random phases: cameras, raw matrices and limit extremes
	task automatic test_random_runs();
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_camera(721, 609, 172, 0, 1237, 370);
				1: set_camera($urandom_range(200, 2047), $urandom_range(0, 2047),
					$urandom_range(0, 2047), int'($urandom), 4095, 1);
				2: begin
					for (int r = 0; r <= CFG_ROW2_B; r++)
						write_reg(4'(r), {$urandom, $urandom});
					write_reg(CFG_LIMIT_X, 64'(4095));
					write_reg(CFG_LIMIT_Y, 64'(4095));
				end
				3: begin
					set_camera(900, 700, 300, 4096, $urandom_range(1, 4095),
						$urandom_range(1, 4095));
					write_reg(4'(CFG_LIMIT_Y) + 4'd1, {$urandom, $urandom});
					write_reg(4'hF, 64'hFFFF_FFFF_FFFF_FFFF);
				end
				4: begin
					for (int r = 0; r <= CFG_ROW2_B; r++)
						write_reg(4'(r), 64'hFFFF_FFFF_FFFF_FFFF);
					write_reg(CFG_LIMIT_X, 64'hFFF);
					write_reg(CFG_LIMIT_Y, 64'(1));
				end
				default: begin
					set_camera(650, 640, 360, 0, 1279, 719);
					calm = 1'b1;
				end
			endcase
			repeat (270)
				send_box(rand_box());
			drain();
		end
	endtask

	initial begin
		fill_sine();
		for (int r = 0; r < 6; r++)
			proj_rows[r] = '0;
		limit_x     = LIMIT_X_RESET;
		limit_y     = LIMIT_Y_RESET;
		failed      = 1'b0;
		calm        = 1'b0;
		hold_req    = 1'b0;
		hold_cnt    = 0;
		stall_cnt   = 0;
		cycle_count = 0;
		arst_n      = 1'b0;
		s_tdata     = '0;
		s_tvalid    = 1'b0;
		m_tready    = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_matrix();
		test_extremes();
		test_behind_camera();
		test_backpressure();
		test_random_runs();

		if (!failed)
			$display("[box_to_image_bbox_projector_core] OK");
		else
			$display("[box_to_image_bbox_projector_core] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/bbproj_pkg.sv
rtl/box_to_image_bbox_projector_core.sv
tb/testbench.sv
